// File: sv/itbl_pkg.sv
// Shared types, widths and constants for the interval and token bucket limiter.
`timescale 1ns / 1ps

package itbl_pkg;

  // Field and state widths.
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned TOKEN_W    = 24;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned INTERVAL_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Refill arithmetic. Within one second the elapsed time is below 1000 and fits 10 bits.
  localparam int unsigned MS_PER_SEC  = 1000;
  localparam int unsigned ELAPSED_W   = 10;
  // floor(p / 1000) == (p * RECIP) >> RECIP_SHIFT for every p below 2^34.
  localparam int unsigned RECIP_SHIFT = 44;
  localparam int unsigned RECIP_W     = 35;
  localparam logic [RECIP_W-1:0] RECIP = 35'd17592186045;
  localparam int unsigned SCALED_W    = TOKEN_W + RECIP_W;
  localparam int unsigned PROD_W      = ELAPSED_W + SCALED_W;
  localparam int unsigned ADD_W       = PROD_W - RECIP_SHIFT;
  localparam int unsigned SUM_W       = ADD_W + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Action codes carried by an input item.
  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_RESET   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_SEC  = 2'd1;

endpackage

// File: sv/interval_and_token_bucket_limiter_top.sv
// Top level of the interval and token bucket request limiter.
`timescale 1ns / 1ps

//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_ready_o    action_i, now_ms_i
//  out      output     out_valid_o / out_ready_i  granted_o, rejected_total_o
//  cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// The transfer edge loads an item into the input register, and a later edge on which the
// result register is free or being emptied moves it through the decision logic into the
// result register, from which it is shown. A new item is taken every cycle while the
// output does not stall; the limiter state is read and rewritten in the same cycle as the
// decision, so each item sees the state left by the one before. Reset clears all control
// state and the limiter state with no clearing pass. When the output stalls, the input
// register holds its item and in_ready_o stays high only while that register is free.

module interval_and_token_bucket_limiter_top
  import itbl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic [TIME_W-1:0]     now_ms_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  granted_o,
  output logic [COUNT_W-1:0]    rejected_total_o,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration. The bucket size is also kept pre-multiplied by the reciprocal of
  // 1000, so the refill needs one multiplication per item and no division.
  logic [INTERVAL_W-1:0] min_interval_q;
  logic [TOKEN_W-1:0]    max_per_sec_q;
  logic [SCALED_W-1:0]   max_scaled_q, max_scaled_d;

  // Input register.
  logic                  in_valid_q;
  logic                  action_q;
  logic [TIME_W-1:0]     now_q;

  // Limiter state.
  logic [TIME_W-1:0]     last_grant_q, last_grant_d;
  logic [TIME_W-1:0]     last_refill_q, last_refill_d;
  logic [TOKEN_W-1:0]    tokens_q, tokens_d;
  logic [COUNT_W-1:0]    rejects_q, rejects_d;

  // Result register.
  logic                  out_valid_q;
  logic                  granted_q, granted_d;
  logic [COUNT_W-1:0]    total_q;

  // Decision datapath.
  logic                  advance;
  logic [TIME_W-1:0]     since_grant;
  logic [TIME_W-1:0]     since_refill;
  logic                  too_soon;
  logic                  full_second;
  logic [PROD_W-1:0]     refill_prod;
  logic [ADD_W-1:0]      refill_add;
  logic [SUM_W-1:0]      refill_sum;
  logic [TOKEN_W-1:0]    refilled;
  logic [COUNT_W-1:0]    rejects_inc;

  // The decision stage moves whenever it holds an item and the result register is
  // free or being emptied in this cycle.
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  assign max_scaled_d = SCALED_W'(cfg_data_i[TOKEN_W-1:0]) * SCALED_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_interval_q <= '0;
      max_per_sec_q  <= '0;
      max_scaled_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MIN_INTERVAL: min_interval_q <= cfg_data_i[INTERVAL_W-1:0];
        CFG_MAX_PER_SEC: begin
          max_per_sec_q <= cfg_data_i[TOKEN_W-1:0];
          max_scaled_q  <= max_scaled_d;
        end
        default: ;
      endcase
    end
  end

  // Both time differences wrap modulo the time stamp width, as the stamps do.
  assign since_grant  = now_q - last_grant_q;
  assign since_refill = now_q - last_refill_q;
  assign too_soon     = (min_interval_q != '0)
                        && (since_grant < TIME_W'(min_interval_q));
  assign full_second  = since_refill >= TIME_W'(MS_PER_SEC);

  // Tokens earned since the last refill: elapsed * limit / 1000, rounded down. Only
  // used when less than a second has gone by, so the low bits of the elapsed time do.
  assign refill_prod = PROD_W'(since_refill[ELAPSED_W-1:0]) * PROD_W'(max_scaled_q);
  assign refill_add  = refill_prod[PROD_W-1:RECIP_SHIFT];
  assign refill_sum  = SUM_W'(tokens_q) + SUM_W'(refill_add);

  always_comb begin
    if (full_second) begin
      refilled = max_per_sec_q;
    end else if (refill_sum > SUM_W'(max_per_sec_q)) begin
      refilled = max_per_sec_q;
    end else begin
      refilled = refill_sum[TOKEN_W-1:0];
    end
  end

  assign rejects_inc = (rejects_q == COUNT_MAX) ? rejects_q : rejects_q + COUNT_W'(1);

  always_comb begin
    last_grant_d  = last_grant_q;
    last_refill_d = last_refill_q;
    tokens_d      = tokens_q;
    rejects_d     = rejects_q;
    granted_d     = 1'b0;
    if (action_q == ACT_RESET) begin
      // A limiter reset starts a fresh second with a full bucket.
      last_grant_d  = '0;
      last_refill_d = now_q;
      tokens_d      = max_per_sec_q;
      rejects_d     = '0;
    end else if (too_soon) begin
      rejects_d = rejects_inc;
    end else if (max_per_sec_q != '0) begin
      // The bucket is refilled even when it then turns the request away.
      last_refill_d = now_q;
      if (refilled == '0) begin
        tokens_d  = '0;
        rejects_d = rejects_inc;
      end else begin
        tokens_d     = refilled - TOKEN_W'(1);
        last_grant_d = now_q;
        granted_d    = 1'b1;
      end
    end else begin
      last_grant_d = now_q;
      granted_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      last_grant_q  <= '0;
      last_refill_q <= '0;
      tokens_q      <= '0;
      rejects_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q   <= 1'b1;
        last_grant_q  <= last_grant_d;
        last_refill_q <= last_refill_d;
        tokens_q      <= tokens_d;
        rejects_q     <= rejects_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      action_q <= action_i;
      now_q    <= now_ms_i;
    end
    if (advance) begin
      granted_q <= granted_d;
      total_q   <= rejects_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign granted_o        = granted_q;
  assign rejected_total_o = total_q;

endmodule

// File: sv/itbl_checker.sv
// Port-level checker for the limiter top level, with its bind statement.
`timescale 1ns / 1ps

module itbl_checker
  import itbl_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  granted_o,
  input logic [COUNT_W-1:0]    rejected_total_o
);

  logic               out_xfer;
  logic [COUNT_W-1:0] prev_total_q;

  assign out_xfer = out_valid_o && out_ready_i;

  // Reject count carried by the last result transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_total_q <= '0;
    end else if (out_xfer) begin
      prev_total_q <= rejected_total_o;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before its transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(granted_o) && $stable(rejected_total_o))
    else $error("result changed while stalled");

  // A grant leaves the reject count as the previous item left it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && granted_o |-> rejected_total_o == prev_total_q)
    else $error("reject count moved on a grant");

  // A refusal counts one more (or holds at full scale); a limiter reset clears the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !granted_o |->
      rejected_total_o == '0
      || rejected_total_o == prev_total_q + COUNT_W'(1)
      || (rejected_total_o == COUNT_MAX && prev_total_q == COUNT_MAX))
    else $error("reject count stepped wrongly");

endmodule

bind interval_and_token_bucket_limiter_top itbl_checker u_itbl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .granted_o        (granted_o),
  .rejected_total_o (rejected_total_o)
);

// File: sim/itbl_limiter_checker.sv
// Checker that predicts every limiter decision and compares it with the results of the block.
`timescale 1ns / 1ps

module itbl_limiter_checker
  import itbl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  action_i,
  input  logic [TIME_W-1:0]     now_ms_i,

  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic                  granted_i,
  input  logic [COUNT_W-1:0]    rejected_total_i,

  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  output logic [31:0]           fail_count_o,
  output logic [31:0]           pending_o,
  output logic [31:0]           grant_count_o,
  output logic [31:0]           denial_count_o,
  output logic [31:0]           reset_count_o
);

  // Only the first few mismatches are printed; all of them are counted.
  localparam int unsigned MAX_REPORTS = 40;

  typedef struct packed {
    logic               granted;
    logic [COUNT_W-1:0] total;
  } decision_t;

  // Register copies and limiter state as the block should hold them.
  logic [INTERVAL_W-1:0] min_gap_ms;
  logic [TOKEN_W-1:0]    bucket_limit;
  logic [TIME_W-1:0]     last_grant_ms;
  logic [TOKEN_W-1:0]    tokens;
  logic [TIME_W-1:0]     last_refill_ms;
  logic [COUNT_W-1:0]    rejects;

  decision_t   expected_decisions[$];
  decision_t   oldest;
  decision_t   fresh;
  int unsigned fails = 0;
  int unsigned pending = 0;
  int unsigned results_seen = 0;
  int unsigned grants = 0;
  int unsigned denials = 0;
  int unsigned resets = 0;

  assign fail_count_o   = fails;
  assign pending_o      = pending;
  assign grant_count_o  = grants;
  assign denial_count_o = denials;
  assign reset_count_o  = resets;

  task automatic report_mismatch(input string msg);
    if (fails < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    fails++;
  endtask

  task automatic bump_rejects();
    if (rejects != COUNT_MAX) rejects = rejects + 1'b1;
    denials++;
  endtask

  task automatic predict_decision(input logic act, input logic [TIME_W-1:0] now,
                                  output decision_t d);
    logic [TIME_W-1:0] since_grant;
    logic [TIME_W-1:0] since_refill;
    logic [63:0]       refilled;
    logic              ok;
    ok = 1'b0;
    if (act == ACT_RESET) begin
      last_grant_ms  = '0;
      rejects        = '0;
      tokens         = bucket_limit;
      last_refill_ms = now;
      resets++;
    end else begin
      since_grant = now - last_grant_ms;
      if (min_gap_ms != '0 && since_grant < {{(TIME_W-INTERVAL_W){1'b0}}, min_gap_ms}) begin
        bump_rejects();
      end else begin
        ok = 1'b1;
        if (bucket_limit != '0) begin
          since_refill = now - last_refill_ms;
          if (since_refill >= MS_PER_SEC) begin
            tokens = bucket_limit;
          end else begin
            // Below one second the product stays well inside 64 bits.
            refilled = 64'(tokens) + (64'(since_refill) * 64'(bucket_limit)) / 64'(MS_PER_SEC);
            if (refilled > 64'(bucket_limit)) refilled = 64'(bucket_limit);
            tokens = refilled[TOKEN_W-1:0];
          end
          last_refill_ms = now;
          if (tokens == '0) begin
            bump_rejects();
            ok = 1'b0;
          end else begin
            tokens = tokens - 1'b1;
          end
        end
        if (ok) begin
          last_grant_ms = now;
          grants++;
        end
      end
    end
    d.granted = ok;
    d.total   = rejects;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_ms     = '0;
      bucket_limit   = '0;
      last_grant_ms  = '0;
      tokens         = '0;
      last_refill_ms = '0;
      rejects        = '0;
      expected_decisions.delete();
      pending        = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MIN_INTERVAL: min_gap_ms   = cfg_data_i[INTERVAL_W-1:0];
          CFG_MAX_PER_SEC:  bucket_limit = cfg_data_i[TOKEN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        results_seen++;
        if (expected_decisions.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no decision pending",
                                    results_seen));
        end else begin
          oldest = expected_decisions.pop_front();
          if (granted_i !== oldest.granted)
            report_mismatch($sformatf("result %0d: granted %b, predicted %b",
                                      results_seen, granted_i, oldest.granted));
          if (rejected_total_i !== oldest.total)
            report_mismatch($sformatf("result %0d: rejected_total %0d, predicted %0d",
                                      results_seen, rejected_total_i, oldest.total));
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_decision(action_i, now_ms_i, fresh);
        expected_decisions.push_back(fresh);
      end
      pending = expected_decisions.size();
    end
  end

endmodule

// File: sim/tb_interval_and_token_bucket_limiter_top.sv
// Testbench top for the limiter: stimulus, handshake pacing, watchdog and the verdict.
`timescale 1ns / 1ps

module tb_interval_and_token_bucket_limiter_top;
  import itbl_pkg::*;

  // Rough size of the random part, counted in input transfers.
  localparam int unsigned RANDOM_ITEMS     = 550;
  // The receiver holds off this long once, so that the block fills and stalls its input.
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  // Quiet cycles after the last result.
  localparam int unsigned TAIL_CYCLES      = 20;
  // Far above the slowest correct run.
  localparam int unsigned CYCLE_LIMIT      = 400000;

  localparam logic [TIME_W-1:0] TIME_TOP = '1;

  // Indexes that name no register; transfers to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  action_i;
  logic [TIME_W-1:0]     now_ms_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  granted_o;
  logic [COUNT_W-1:0]    rejected_total_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  logic [31:0] fail_count;
  logic [31:0] pending;
  logic [31:0] grant_count;
  logic [31:0] denial_count;
  logic [31:0] reset_count;

  // Pacing controls shared between the sender and the receiver. Each variable has a
  // single writer: hold_asks belongs to the sender, holds_served to the receiver.
  bit          sender_quiet = 1'b0;
  bit          receiver_quiet = 1'b0;
  int unsigned hold_asks = 0;
  int unsigned holds_served = 0;
  int unsigned items_sent = 0;
  int unsigned settings_used = 0;

  interval_and_token_bucket_limiter_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .now_ms_i         (now_ms_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .granted_o        (granted_o),
    .rejected_total_o (rejected_total_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  itbl_limiter_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .action_i         (action_i),
    .now_ms_i         (now_ms_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .granted_i        (granted_o),
    .rejected_total_i (rejected_total_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .grant_count_o    (grant_count),
    .denial_count_o   (denial_count),
    .reset_count_o    (reset_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // The watchdog gives up on a run that hangs, for instance on a ready that never rises.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Run stopped by the watchdog after %0d cycles.", cycles);
    $display("TB_ERROR");
    $finish;
  end

  // Gap after a transfer: mostly none, often a few cycles, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sender_quiet) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TIME_W-1:0] random_stamp();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Offers one item and returns at the edge of its transfer. Valid is left high when
  // no gap follows, so the next item follows without a bubble; whoever ends a burst
  // lowers it.
  task automatic send_item(input logic act, input logic [TIME_W-1:0] stamp);
    int unsigned gap;
    in_valid_i <= 1'b1;
    action_i   <= act;
    now_ms_i   <= stamp;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Ends the current burst and waits until every predicted result has been transferred.
  // Each item yields exactly one result, so an empty queue means the block is idle.
  task automatic drain_decisions();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Register writes go back to back; valid only drops once the last one is through.
  task automatic load_settings(input bit write_gap, input bit write_limit, input bit spare,
                               input logic [31:0] gap_ms, input logic [31:0] limit_word);
    if (write_gap) cfg_write(CFG_MIN_INTERVAL, gap_ms);
    if (write_limit) cfg_write(CFG_MAX_PER_SEC, limit_word);
    if (spare) begin
      cfg_write(CFG_SPARE_LO, $urandom);
      cfg_write(CFG_SPARE_HI, $urandom);
    end
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // The receiver mostly accepts, sometimes stalls for a while, and once holds off for a
  // long stretch when the sender asks for it.
  initial begin : receiver
    int unsigned idle_left;
    idle_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != holds_served) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        holds_served++;
      end else if (receiver_quiet || !rst_ni) begin
        out_ready_i <= 1'b1;
      end else if (idle_left > 0) begin
        out_ready_i <= 1'b0;
        idle_left--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 99) < 20)
          idle_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      end
    end
  end

  initial begin : stimulus
    logic [TIME_W-1:0] clock_ms;
    logic [31:0]       gap_ms;
    logic [23:0]       limit;
    int unsigned       random_start;
    int unsigned       phase_len;
    int unsigned       r;
    int unsigned       n;
    bit                first_random;
    logic              act;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    action_i    <= ACT_REQUEST;
    now_ms_i    <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_MIN_INTERVAL;
    cfg_data_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the reset values both checks are off, so every request is granted, at either
    // end of the time range.
    send_item(ACT_REQUEST, '0);
    send_item(ACT_REQUEST, TIME_TOP);
    send_item(ACT_RESET, TIME_TOP);
    drain_decisions();

    // A 5 ms spacing and a bucket of three tokens; the upper data bits of the limit write
    // must be dropped. The spare indexes are written with noise as well.
    load_settings(1'b1, 1'b1, 1'b1, 32'd5, 32'hFF00_0003);
    send_item(ACT_RESET, 48'd3);
    send_item(ACT_REQUEST, 48'd4);     // too close to time zero after the reset
    send_item(ACT_REQUEST, 48'd10);
    send_item(ACT_REQUEST, 48'd12);    // inside the spacing
    send_item(ACT_REQUEST, 48'd15);
    send_item(ACT_REQUEST, 48'd20);    // takes the last token
    send_item(ACT_REQUEST, 48'd25);    // empty bucket
    send_item(ACT_REQUEST, 48'd1025);  // a full second refills the bucket
    send_item(ACT_REQUEST, 48'd1026);
    drain_decisions();

    // The largest bucket, with time stamps that cross the wrap of the time counter.
    load_settings(1'b1, 1'b1, 1'b0, 32'd0, 32'h00FF_FFFF);
    send_item(ACT_RESET, TIME_TOP - 48'd100);
    send_item(ACT_REQUEST, TIME_TOP - 48'd50);
    send_item(ACT_REQUEST, 48'd400);
    send_item(ACT_REQUEST, 48'd1500);
    drain_decisions();

    // Fill a bucket of 1000, then shrink the limit without a reset: the next refill has
    // to cap the bucket at the new limit.
    load_settings(1'b1, 1'b1, 1'b0, 32'd0, 32'd1000);
    send_item(ACT_RESET, 48'd5000);
    drain_decisions();
    load_settings(1'b0, 1'b1, 1'b0, 32'd0, 32'd2);
    send_item(ACT_REQUEST, 48'd5001);
    send_item(ACT_REQUEST, 48'd5002);
    send_item(ACT_REQUEST, 48'd5003);
    drain_decisions();

    // The widest spacing with a single token.
    load_settings(1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'd1);
    send_item(ACT_RESET, 48'd7);
    send_item(ACT_REQUEST, 48'd8);
    send_item(ACT_REQUEST, 48'h1_0000_0000);
    send_item(ACT_REQUEST, 48'h1_0000_0001);
    drain_decisions();

    // Random phases. Each one starts from an idle block with new register values and,
    // as software would, usually a reset item; then a run of time stamps that mostly
    // advance a little, sometimes by seconds, and rarely jump or go backwards.
    clock_ms     = 48'h1_0000_0001;
    random_start = items_sent;
    first_random = 1'b1;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      case (r)
        1:       gap_ms = 32'hFFFF_FFFF;
        2, 3, 4: gap_ms = $urandom_range(1, 20);
        5, 6:    gap_ms = $urandom_range(21, 1500);
        7:       gap_ms = $urandom;
        default: gap_ms = '0;
      endcase
      r = $urandom_range(0, 9);
      case (r)
        0:          limit = '0;
        1:          limit = 24'hFF_FFFF;
        2:          limit = 24'd1;
        3, 4, 5, 6: limit = $urandom_range(2, 40);
        7:          limit = $urandom_range(41, 5000);
        8:          limit = 24'($urandom);
        default:    limit = 24'($urandom_range(0, 3));
      endcase
      r = $urandom_range(0, 9);
      load_settings(r != 0, r != 1, r == 2, gap_ms, {8'($urandom), limit});

      sender_quiet   = ($urandom_range(0, 5) == 0);
      receiver_quiet = sender_quiet;
      phase_len      = $urandom_range(25, 60);
      if (first_random) begin
        // The receiver stops for a long while as the sender keeps offering items.
        hold_asks++;
        sender_quiet   = 1'b1;
        receiver_quiet = 1'b0;
        phase_len      = 40;
        first_random   = 1'b0;
      end

      if ($urandom_range(0, 4) != 0) send_item(ACT_RESET, clock_ms);
      for (n = 0; n < phase_len; n++) begin
        r = $urandom_range(0, 99);
        if (r < 50)      clock_ms = clock_ms + $urandom_range(0, 8);
        else if (r < 75) clock_ms = clock_ms + $urandom_range(0, 40);
        else if (r < 88) clock_ms = clock_ms + $urandom_range(0, 1200);
        else if (r < 95) clock_ms = clock_ms + $urandom_range(0, 100000);
        else if (r < 98) clock_ms = clock_ms + random_stamp();
        else             clock_ms = random_stamp();
        act = ($urandom_range(0, 99) < 4) ? ACT_RESET : ACT_REQUEST;
        send_item(act, clock_ms);
      end
      // The sender waits for every outstanding result before the next register change.
      drain_decisions();
    end

    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);

    $display("Ran %0d items under %0d register settings: %0d granted, %0d rejected, %0d resets.",
             items_sent, settings_used, grant_count, denial_count, reset_count);
    $display("Mismatches found: %0d, results still outstanding: %0d.", fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
